>>> rtl/resd_pkg.sv
// Package for the rotary encoder settle decoder.
// Holds the channel count, field widths, reset constants and shared types.
// No dependencies.
package resd_pkg;

  localparam int unsigned CHANNELS     = 6;
  localparam int unsigned FIELD_W      = 6;
  localparam int unsigned TIME_W       = 32;
  localparam int unsigned SETTLE_W     = 8;
  localparam logic [SETTLE_W-1:0] SETTLE_RESET = 8'd2;

  typedef struct packed {
    logic up;
    logic down;
  } resd_event_t;

endpackage

>>> rtl/resd_chan.sv
// One encoder channel: pending bit, change time, settled A level and the
// settle judgement. Depends on resd_pkg.
module resd_chan
  import resd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                a_i,
  input  logic                b_i,
  input  logic [TIME_W-1:0]   now_i,
  input  logic [SETTLE_W-1:0] settle_ms_i,
  output resd_event_t         ev_o
);

  logic              pending_q, pending_d;
  logic              settled_q, settled_d;
  logic [TIME_W-1:0] change_time_q, change_time_d;
  logic [TIME_W-1:0] elapsed;
  logic              judge;
  logic              pend_mid;
  logic              settled_mid;

  always_comb begin
    elapsed       = now_i - change_time_q;
    judge         = pending_q && (elapsed > {{(TIME_W-SETTLE_W){1'b0}}, settle_ms_i});
    ev_o.up       = judge && (a_i != settled_q) && (a_i == b_i);
    ev_o.down     = judge && (a_i != settled_q) && (a_i != b_i);
    pend_mid      = judge ? 1'b0 : pending_q;
    settled_mid   = judge ? a_i : settled_q;
    pending_d     = pend_mid;
    settled_d     = settled_mid;
    change_time_d = change_time_q;
    if (!pend_mid && (a_i != settled_mid)) begin
      pending_d     = 1'b1;
      change_time_d = now_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 1'b0;
      settled_q <= 1'b0;
    end else if (en_i) begin
      pending_q <= pending_d;
      settled_q <= settled_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      change_time_q <= change_time_d;
    end
  end

endmodule

>>> rtl/rotary_encoder_settle_decoder_unit.sv
// Top level of the rotary encoder settle decoder.
// Holds the input register, the per-channel decoders, the sticky flags and
// the result register. Depends on resd_pkg and resd_chan.

// The block takes one scan request per clock cycle while the output is not
// held by out_ready_i, and returns one result per scan: the scan is captured
// in an input register, all channels are judged in parallel from it and the
// sticky flags land in the result register. The rate is set by the channel
// update, one 32-bit elapsed-time subtract and compare per channel. The
// settle register may be written only while no scan is in flight; it resets
// to 2 ms.
module rotary_encoder_settle_decoder_unit
  import resd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [SETTLE_W-1:0] cfg_settle_ms_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [FIELD_W-1:0]  a_levels_i,
  input  logic [FIELD_W-1:0]  b_levels_i,
  input  logic [TIME_W-1:0]   now_ms_i,
  input  logic                take_report_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [FIELD_W-1:0]  up_events_o,
  output logic [FIELD_W-1:0]  down_events_o
);

  logic [SETTLE_W-1:0] settle_q;
  logic                in_valid_q;
  logic [FIELD_W-1:0]  a_q, b_q;
  logic [TIME_W-1:0]   now_q;
  logic                take_q;
  logic                out_valid_q;
  logic [FIELD_W-1:0]  up_events_q, down_events_q;
  logic [CHANNELS-1:0] up_flags_q, up_flags_d;
  logic [CHANNELS-1:0] down_flags_q, down_flags_d;
  logic [CHANNELS-1:0] up_next, down_next;
  logic [CHANNELS-1:0] a_ext, b_ext;
  logic [FIELD_W-1:0]  up_vis, down_vis;
  resd_event_t         ev [CHANNELS];
  logic                advance;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_q <= SETTLE_RESET;
    end else if (cfg_valid_i) begin
      settle_q <= cfg_settle_ms_i;
    end
  end

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      a_q    <= a_levels_i;
      b_q    <= b_levels_i;
      now_q  <= now_ms_i;
      take_q <= take_report_i;
    end
  end

  for (genvar i = 0; i < CHANNELS; i++) begin : g_chan
    if (i < FIELD_W) begin : g_vis
      assign a_ext[i] = a_q[i];
      assign b_ext[i] = b_q[i];
    end else begin : g_hid
      assign a_ext[i] = 1'b0;
      assign b_ext[i] = 1'b0;
    end

    resd_chan u_chan (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .en_i       (advance),
      .a_i        (a_ext[i]),
      .b_i        (b_ext[i]),
      .now_i      (now_q),
      .settle_ms_i(settle_q),
      .ev_o       (ev[i])
    );

    assign up_next[i]   = up_flags_q[i] | ev[i].up;
    assign down_next[i] = down_flags_q[i] | ev[i].down;
  end

  for (genvar j = 0; j < FIELD_W; j++) begin : g_out
    if (j < CHANNELS) begin : g_map
      assign up_vis[j]   = up_next[j];
      assign down_vis[j] = down_next[j];
    end else begin : g_pad
      assign up_vis[j]   = 1'b0;
      assign down_vis[j] = 1'b0;
    end
  end

  assign up_flags_d   = take_q ? '0 : up_next;
  assign down_flags_d = take_q ? '0 : down_next;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      up_flags_q   <= '0;
      down_flags_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (advance) begin
        up_flags_q   <= up_flags_d;
        down_flags_q <= down_flags_d;
        out_valid_q  <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      up_events_q   <= up_vis;
      down_events_q <= down_vis;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign up_events_o   = up_events_q;
  assign down_events_o = down_events_q;

endmodule
